// File: rtl/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types, widths and codes of the Chinese remainder solver.
// ----------------------------------------------------------------------------
`default_nettype none

package crt_pkg;

  localparam int MAX_MODULI_DEF = 4;
  localparam int MOD_WIDTH_DEF  = 16;

  localparam int FLD_W   = 16;
  localparam int ACC_W   = 64;
  localparam int STAT_W  = 2;
  localparam int SGN_W   = FLD_W + 2;
  localparam int DCNT_W  = $clog2(ACC_W);

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOCOPR = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVFL   = 2'd2;

  typedef struct packed {
    logic [FLD_W-1:0] residue;
    logic [FLD_W-1:0] modulus;
    logic             is_last;
  } in_word_t;

  typedef struct packed {
    logic [ACC_W-1:0]  solution;
    logic [ACC_W-1:0]  product;
    logic [STAT_W-1:0] status;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_START,
    OP_READ,
    OP_READ_J,
    OP_PMUL,
    OP_PAIR_INIT,
    OP_GLOAD,
    OP_GSTEP,
    OP_GEND,
    OP_SOL_INIT,
    OP_DIV_PART,
    OP_PMOD,
    OP_AMOD,
    OP_EINIT,
    OP_ESTART,
    OP_EUPD,
    OP_INV,
    OP_CSTART,
    OP_CMUL,
    OP_ACC,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic ovf;
    logic bad;
    logic i_last;
    logic n_lt2;
    logic pair_last;
    logic gcd_done;
    logic r1_zero;
    logic div_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/crt_div.sv
// ----------------------------------------------------------------------------
// crt_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [crt_pkg::ACC_W-1:0] dividend,
  input  wire logic [crt_pkg::FLD_W-1:0] divisor,
  output logic                           busy,
  output logic [crt_pkg::ACC_W-1:0]      quotient,
  output logic [crt_pkg::FLD_W-1:0]      remainder
);
  import crt_pkg::*;

  logic              busy_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [ACC_W-1:0]  acc_r;
  logic [FLD_W-1:0]  rem_r;
  logic [FLD_W-1:0]  dvs_r;
  logic [FLD_W:0]    trial;
  logic [FLD_W:0]    diff;
  logic              take;

  assign trial = {rem_r, acc_r[ACC_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '1;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[ACC_W-2:0], take};
      rem_r <= take ? diff[FLD_W-1:0] : trial[FLD_W-1:0];
    end
  end

  assign busy      = busy_r;
  assign quotient  = acc_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: rtl/crt_dp.sv
// ----------------------------------------------------------------------------
// crt_dp
// Datapath: congruence stores, product, gcd, inverse and accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_dp #(
  parameter int MAX_MODULI = crt_pkg::MAX_MODULI_DEF,
  parameter int MOD_WIDTH  = crt_pkg::MOD_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire crt_pkg::dp_op_t    op,
  input  wire crt_pkg::in_word_t  in_data,
  output crt_pkg::dp_sts_t        sts,
  output crt_pkg::out_word_t      out_data
);
  import crt_pkg::*;

  localparam int CNT_W = $clog2(MAX_MODULI + 1);
  localparam int IDX_W = (MAX_MODULI > 1) ? $clog2(MAX_MODULI) : 1;

  logic [MOD_WIDTH-1:0] res_mem [MAX_MODULI];
  logic [MOD_WIDTH-1:0] mod_mem [MAX_MODULI];

  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic              bad_r;
  logic [IDX_W-1:0]  i_r, j_r, rd_addr;
  logic [FLD_W-1:0]  m_q_r, a_q_r, gu_r, u_r, v_r;
  logic [FLD_W-1:0]  r0_r, r1_r, ar_r, inv_r;
  logic signed [SGN_W-1:0] s0_r, s1_r;
  logic [ACC_W-1:0]  prod_r, part_r, sol_r, pc_r;
  out_word_t         out_r;

  logic              div_start, div_busy;
  logic [ACC_W-1:0]  div_dvd, div_quot;
  logic [FLD_W-1:0]  div_dvs, div_rem;

  logic [CNT_W-1:0]  n_m1, n_m2;
  logic [ACC_W+FLD_W-1:0] prod_mul, pc_mul;
  logic [2*FLD_W-1:0] coefp;
  logic signed [2*SGN_W-1:0] qs;
  logic signed [SGN_W-1:0] s_new, inv_sum;
  logic [ACC_W-1:0]  diff;

  assign rd_addr = (op == OP_READ_J) ? j_r : i_r;
  assign n_m1    = cnt_r - 1'b1;
  assign n_m2    = cnt_r - 2'd2;
  assign prod_mul = prod_r * m_q_r;
  assign pc_mul   = part_r * div_rem;
  assign coefp    = ar_r * inv_r;
  assign qs       = $signed({2'b00, div_quot[FLD_W-1:0]}) * s1_r;
  assign s_new    = s0_r - qs[SGN_W-1:0];
  assign inv_sum  = s0_r + $signed({2'b00, m_q_r});
  assign diff     = prod_r - pc_r;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = prod_r;
    div_dvs   = m_q_r;
    unique case (op)
      OP_DIV_PART: div_start = 1'b1;
      OP_PMOD: begin
        div_start = 1'b1;
        div_dvd   = div_quot;
      end
      OP_AMOD: begin
        div_start = 1'b1;
        div_dvd   = ACC_W'(a_q_r);
      end
      OP_ESTART: begin
        div_start = 1'b1;
        div_dvd   = ACC_W'(r0_r);
        div_dvs   = r1_r;
      end
      OP_CSTART: begin
        div_start = 1'b1;
        div_dvd   = ACC_W'(coefp);
      end
      default: div_start = 1'b0;
    endcase
  end

  crt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (op == OP_LOAD && cnt_r < CNT_W'(MAX_MODULI)) begin
      res_mem[cnt_r[IDX_W-1:0]] <= in_data.residue[MOD_WIDTH-1:0];
      mod_mem[cnt_r[IDX_W-1:0]] <= in_data.modulus[MOD_WIDTH-1:0];
    end
    m_q_r <= FLD_W'(mod_mem[rd_addr]);
    a_q_r <= FLD_W'(res_mem[rd_addr]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (op == OP_LOAD) begin
      if (cnt_r < CNT_W'(MAX_MODULI)) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        ovf_r <= 1'b1;
      end
    end else if (op == OP_OUT) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_START: begin
        prod_r <= ACC_W'(1);
        i_r    <= '0;
        bad_r  <= 1'b0;
      end
      OP_PMUL: begin
        prod_r <= prod_mul[ACC_W-1:0];
        if (m_q_r == '0) begin
          bad_r <= 1'b1;
        end
        i_r <= i_r + 1'b1;
      end
      OP_PAIR_INIT: begin
        i_r <= '0;
        j_r <= IDX_W'(1);
      end
      OP_READ_J: gu_r <= m_q_r;
      OP_GLOAD: begin
        if (!gu_r[0] && !m_q_r[0]) begin
          bad_r <= 1'b1;
        end
        if (gu_r[0]) begin
          u_r <= gu_r;
          v_r <= m_q_r;
        end else begin
          u_r <= m_q_r;
          v_r <= gu_r;
        end
      end
      OP_GSTEP: begin
        if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r <= v_r) begin
          v_r <= v_r - u_r;
        end else begin
          u_r <= v_r;
          v_r <= u_r - v_r;
        end
      end
      OP_GEND: begin
        if (u_r != FLD_W'(1)) begin
          bad_r <= 1'b1;
        end
        if (CNT_W'(j_r) == n_m1) begin
          i_r <= i_r + 1'b1;
          j_r <= IDX_W'(i_r + 2'd2);
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      OP_SOL_INIT: begin
        i_r   <= '0;
        sol_r <= '0;
      end
      OP_PMOD: part_r <= div_quot;
      OP_AMOD: begin
        r1_r <= div_rem;
        r0_r <= m_q_r;
        s0_r <= '0;
        s1_r <= SGN_W'(1);
      end
      OP_EINIT: ar_r <= div_rem;
      OP_EUPD: begin
        r0_r <= r1_r;
        r1_r <= div_rem;
        s0_r <= s1_r;
        s1_r <= s_new;
      end
      OP_INV: inv_r <= s0_r[SGN_W-1] ? inv_sum[FLD_W-1:0] : s0_r[FLD_W-1:0];
      OP_CMUL: pc_r <= pc_mul[ACC_W-1:0];
      OP_ACC: begin
        sol_r <= (sol_r >= diff) ? sol_r - diff : sol_r + pc_r;
        i_r   <= i_r + 1'b1;
      end
      OP_OUT: begin
        if (ovf_r) begin
          out_r <= '{solution: '0, product: '0, status: ST_OVFL};
        end else if (bad_r) begin
          out_r <= '{solution: '0, product: prod_r, status: ST_NOCOPR};
        end else begin
          out_r <= '{solution: sol_r, product: prod_r, status: ST_OK};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.ovf       = ovf_r;
    sts.bad       = bad_r;
    sts.i_last    = CNT_W'(i_r) == n_m1;
    sts.n_lt2     = cnt_r <= CNT_W'(1);
    sts.pair_last = (CNT_W'(i_r) == n_m2) && (CNT_W'(j_r) == n_m1);
    sts.gcd_done  = v_r == '0;
    sts.r1_zero   = r1_r == '0;
    sts.div_busy  = div_busy;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// File: rtl/crt_ctrl.sv
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer that steps the datapath through load, check and solve.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_last,
  input  wire logic             out_stall,
  input  wire crt_pkg::dp_sts_t sts,
  output logic                  in_stall,
  output logic                  out_valid,
  output crt_pkg::dp_op_t       op
);
  import crt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_PRD, S_PMUL, S_GINIT, S_GRI, S_GRJ, S_GLD, S_GRUN,
    S_GCHK, S_SINIT, S_SRD, S_D1, S_W1, S_W2, S_W3, S_EU, S_EW, S_C1,
    S_CW, S_ACC, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op            = OP_NOP;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (in_last) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (sts.ovf) begin
          state_nxt = S_DONE;
        end else begin
          op        = OP_START;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        op        = OP_READ;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        op        = OP_PMUL;
        state_nxt = sts.i_last ? S_GINIT : S_PRD;
      end
      S_GINIT: begin
        op = OP_PAIR_INIT;
        priority if (sts.bad) state_nxt = S_DONE;
        else if (sts.n_lt2)   state_nxt = S_SINIT;
        else                  state_nxt = S_GRI;
      end
      S_GRI: begin
        if (sts.bad) begin
          state_nxt = S_DONE;
        end else begin
          op        = OP_READ;
          state_nxt = S_GRJ;
        end
      end
      S_GRJ: begin
        op        = OP_READ_J;
        state_nxt = S_GLD;
      end
      S_GLD: begin
        op        = OP_GLOAD;
        state_nxt = S_GRUN;
      end
      S_GRUN: begin
        priority if (sts.bad) begin
          state_nxt = S_DONE;
        end else if (sts.gcd_done) begin
          op        = OP_GEND;
          state_nxt = sts.pair_last ? S_GCHK : S_GRI;
        end else begin
          op = OP_GSTEP;
        end
      end
      S_GCHK: state_nxt = sts.bad ? S_DONE : S_SINIT;
      S_SINIT: begin
        op        = OP_SOL_INIT;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        op        = OP_READ;
        state_nxt = S_D1;
      end
      S_D1: begin
        op        = OP_DIV_PART;
        state_nxt = S_W1;
      end
      S_W1: begin
        if (!sts.div_busy) begin
          op        = OP_PMOD;
          state_nxt = S_W2;
        end
      end
      S_W2: begin
        if (!sts.div_busy) begin
          op        = OP_AMOD;
          state_nxt = S_W3;
        end
      end
      S_W3: begin
        if (!sts.div_busy) begin
          op        = OP_EINIT;
          state_nxt = S_EU;
        end
      end
      S_EU: begin
        if (sts.r1_zero) begin
          op        = OP_INV;
          state_nxt = S_C1;
        end else begin
          op        = OP_ESTART;
          state_nxt = S_EW;
        end
      end
      S_EW: begin
        if (!sts.div_busy) begin
          op        = OP_EUPD;
          state_nxt = S_EU;
        end
      end
      S_C1: begin
        op        = OP_CSTART;
        state_nxt = S_CW;
      end
      S_CW: begin
        if (!sts.div_busy) begin
          op        = OP_CMUL;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        op        = OP_ACC;
        state_nxt = sts.i_last ? S_DONE : S_SRD;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          op            = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/crt_solver.sv
// ----------------------------------------------------------------------------
// crt_solver
// Solves a system of congruences by the Chinese remainder theorem.
// ----------------------------------------------------------------------------
// Channel   Direction  Word        Handshake
// in_       input      in_word_t   in_valid / in_stall
// out_      output     out_word_t  out_valid / out_stall
//
// A congruence that is not the last is taken without stalling the input.
// A system with too many congruences skips the solve: the sequencer goes from its check
// state to its done state. Otherwise the product and gcd checks run first, and each
// congruence is then solved by divisions and Euclid steps on the shared 64-step divider.
// Reset clears the sequencer, the entry count, the overflow flag and the result valid.
// A stalled result holds, and new congruences are taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_solver #(
  parameter int MAX_MODULI = crt_pkg::MAX_MODULI_DEF,
  parameter int MOD_WIDTH  = crt_pkg::MOD_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire crt_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output crt_pkg::out_word_t      out_data
);
  import crt_pkg::*;

  dp_op_t  op;
  dp_sts_t sts;

  crt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.is_last),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .op        (op)
  );

  crt_dp #(
    .MAX_MODULI (MAX_MODULI),
    .MOD_WIDTH  (MOD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/crt_solver_chk.sv
// ----------------------------------------------------------------------------
// crt_solver_chk
// Port checks on the solver's result word, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_solver_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire crt_pkg::out_word_t out_data
);
  import crt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_NOCOPR ||
                  out_data.status == ST_OVFL)
    else $error("unknown status code");

  a_ovfl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OVFL |->
      out_data.solution == '0 && out_data.product == '0)
    else $error("overflow result is not zero");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NOCOPR |-> out_data.solution == '0)
    else $error("failed system carries a solution");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |->
      out_data.solution < out_data.product)
    else $error("solution not below the product");

endmodule

bind crt_solver crt_solver_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/crt_solver_test.sv
// ----------------------------------------------------------------------------
// crt_solver_test
// Drives systems of congruences into the solver and checks every result
// against a predictor of its own, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module crt_solver_test;
  import crt_pkg::*;

  localparam int NMOD = MAX_MODULI_DEF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  crt_solver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  logic [15:0] pend_res[NMOD];
  logic [15:0] pend_mod[NMOD];
  int unsigned pend_cnt;
  bit          pend_ovf;
  out_word_t   answers[$];
  int          errors;
  int          items_sent;
  int          systems_sent;
  int          checked;
  bit          hold_off;
  int          rx_wait;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] gcd64(logic [63:0] p, logic [63:0] q);
    logic [63:0] t;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    return p;
  endfunction

  function automatic logic [63:0] inverse_mod(logic [63:0] v, logic [63:0] n);
    longint r0, r1, s0, s1, qt, t;
    if (n == 1) return 0;
    r0 = n;
    r1 = v % n;
    s0 = 0;
    s1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      t = r0 - qt * r1;
      r0 = r1;
      r1 = t;
      t = s0 - qt * s1;
      s0 = s1;
      s1 = t;
    end
    s0 = s0 % longint'(n);
    if (s0 < 0) s0 += longint'(n);
    return s0;
  endfunction

  function automatic out_word_t solve_system();
    out_word_t   r;
    logic [63:0] prod, sol, mi, part, coef, term;
    bit          bad;
    prod = 1;
    sol = 0;
    bad = 0;
    for (int i = 0; i < pend_cnt; i++) prod = prod * pend_mod[i];
    for (int i = 0; i < pend_cnt; i++) begin
      if (pend_mod[i] == 0) bad = 1;
      for (int j = i + 1; j < pend_cnt; j++)
        if (gcd64(pend_mod[i], pend_mod[j]) != 1) bad = 1;
    end
    if (!bad) begin
      for (int i = 0; i < pend_cnt; i++) begin
        mi = pend_mod[i];
        part = prod / mi;
        coef = ((pend_res[i] % mi) * inverse_mod(part % mi, mi)) % mi;
        term = part * coef;
        if (sol >= prod - term) sol = sol - (prod - term);
        else sol = sol + term;
      end
    end
    r.solution = bad ? 64'd0 : sol;
    r.product = prod;
    r.status = bad ? ST_NOCOPR : ST_OK;
    return r;
  endfunction

  task automatic predict_word(in_word_t w);
    out_word_t r;
    if (pend_cnt < NMOD) begin
      pend_res[pend_cnt] = w.residue;
      pend_mod[pend_cnt] = w.modulus;
      pend_cnt++;
    end else begin
      pend_ovf = 1;
    end
    if (w.is_last) begin
      if (pend_ovf) begin
        r.solution = 0;
        r.product = 0;
        r.status = ST_OVFL;
      end else begin
        r = solve_system();
      end
      answers.push_back(r);
      pend_cnt = 0;
      pend_ovf = 0;
    end
  endtask

  task automatic send_word(logic [15:0] a, logic [15:0] m, bit last);
    in_word_t w;
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    w.residue = a;
    w.modulus = m;
    w.is_last = last;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    items_sent++;
    if (last) systems_sent++;
    @(negedge clk);
  endtask

  task automatic send_system(int n, bit coprime);
    logic [15:0] mods[8];
    logic [15:0] m;
    bit ok;
    for (int i = 0; i < n; i++) begin
      if (coprime && i < NMOD) begin
        do begin
          m = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 255))
                                           : 16'($urandom_range(1, 65535));
          ok = 1;
          for (int j = 0; j < i; j++) if (gcd64(m, mods[j]) != 1) ok = 0;
        end while (!ok);
      end else begin
        m = 16'($urandom_range(0, 65535));
      end
      mods[i] = m;
      send_word(16'($urandom), m, i == n - 1);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (answers.size() != 0);
  endtask

  task automatic test_directed();
    send_word(16'd2, 16'd3, 0);
    send_word(16'd3, 16'd5, 0);
    send_word(16'd2, 16'd7, 1);
    send_word(16'hFFFF, 16'hFFFF, 0);
    send_word(16'hFFFF, 16'hFFFE, 0);
    send_word(16'hFFFF, 16'hFFFD, 0);
    send_word(16'hFFFF, 16'hFFFB, 1);
    send_word(16'd5, 16'd1, 1);
    send_word(16'd9, 16'd4, 0);
    send_word(16'd1, 16'd6, 1);
    send_word(16'd3, 16'd0, 0);
    send_word(16'd2, 16'd7, 1);
    send_word(16'd100, 16'd7, 1);
    for (int i = 0; i < 5; i++) send_word(16'(i), 16'(2 * i + 3), i == 4);
    send_word(16'd0, 16'd1, 0);
    send_word(16'd0, 16'd1, 0);
    send_word(16'd0, 16'd1, 0);
    send_word(16'd0, 16'd1, 0);
    send_word(16'd1, 16'd2, 1);
    wait_drain();
  endtask

  task automatic test_random();
    int kind;
    while (items_sent < 1100) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) send_system($urandom_range(1, NMOD), 1);
      else if (kind < 9) send_system($urandom_range(1, NMOD), 0);
      else send_system($urandom_range(NMOD + 1, NMOD + 3), 1);
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (20000) @(negedge clk);
        hold_off = 0;
      end
    join_none
    for (int k = 0; k < 4; k++) send_system(2, 1);
    wait_drain();
  endtask

  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_stall <= hold_off;
    end else if (rx_wait != 0) begin
      out_stall <= 1'b1;
      if (out_valid) rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rx_wait = $urandom_range(0, 7);
      if (answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        if (out_data.solution !== answers[0].solution) begin
          $display("%0t: solution expected %h actual %h", $time,
                   answers[0].solution, out_data.solution);
          errors++;
        end
        if (out_data.product !== answers[0].product) begin
          $display("%0t: product expected %h actual %h", $time,
                   answers[0].product, out_data.product);
          errors++;
        end
        if (out_data.status !== answers[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   answers[0].status, out_data.status);
          errors++;
        end
        void'(answers.pop_front());
        checked++;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    hold_off = 0;
    rx_wait = 0;
    pend_cnt = 0;
    pend_ovf = 0;
    errors = 0;
    items_sent = 0;
    systems_sent = 0;
    checked = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    repeat (200) @(negedge clk);
    if (answers.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, answers.size());
      errors++;
    end
    $display("Sent %0d congruences in %0d systems, checked %0d results.",
             items_sent, systems_sent, checked);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: crt_solver.f
rtl/crt_pkg.sv
rtl/crt_div.sv
rtl/crt_dp.sv
rtl/crt_ctrl.sv
rtl/crt_solver.sv
rtl/crt_solver_chk.sv
tb/crt_solver_test.sv
